// ----- hw/rtl/illm_pkg.sv -----
package illm_pkg;
   localparam int unsigned CAPACITY = 255;
   localparam logic [7:0] EFF_CAP = 8'(CAPACITY > 255 ? 255 : CAPACITY);

   localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
   localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
   localparam logic [3:0] OP_INS_BEFORE = 4'd2;
   localparam logic [3:0] OP_INS_AFTER  = 4'd3;
   localparam logic [3:0] OP_ERASE      = 4'd4;
   localparam logic [3:0] OP_POP_FRONT  = 4'd5;
   localparam logic [3:0] OP_POP_BACK   = 4'd6;
   localparam logic [3:0] OP_CLEAR      = 4'd7;
   localparam logic [3:0] OP_NEXT       = 4'd8;
   localparam logic [3:0] OP_PREV       = 4'd9;
   localparam logic [3:0] OP_SWAP       = 4'd10;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_NAN    = 3'd1;
   localparam logic [2:0] ST_BADPOS = 3'd2;
   localparam logic [2:0] ST_NOTIN  = 3'd3;
   localparam logic [2:0] ST_EMPTY  = 3'd4;
   localparam logic [2:0] ST_FULL   = 3'd5;

   typedef struct packed {
      logic [7:0] link;
      logic       used;
   } node_type;

   // stored value and prev link share one memory word
   typedef struct packed {
      logic [63:0] value;
      logic [7:0]  prev;
   } word_type;

   function automatic logic in_range(input logic [7:0] p);
      return (p != 8'd0) && (p <= EFF_CAP);
   endfunction

   function automatic logic is_nan(input logic [63:0] v);
      return (v[62:52] == 11'h7ff) && (v[51:0] != 52'd0);
   endfunction
endpackage

// ----- hw/rtl/illm_ram.sv -----
module illm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- hw/rtl/indexed_linked_list_manager_unit.sv -----
// channel | ports           | payload (lsb first)
// request | req_t*          | opcode[3:0] position[11:4] second_position[19:12] value[83:20]
// result  | rsp_t*          | status[2:0] slot[10:3] at_end[11] front[19:12] back[27:20] count[35:28]
//
// one request at a time through a sequencer over two memories with a registered read:
// next link + in-use bit, and stored value + prev link
// a taken request goes through S_RD1 and S_EVAL; errors, queries, clear and unused opcodes
// then go to S_DONE, where the result is registered; swap goes through S_SWP1 and S_SWP2,
// push, erase and pop through S_W1 to S_W3, and insert through S_RD2 and S_W1 to S_W3 first
// after reset, and after the result of every clear, a sweep over all 256 entries rebuilds the
// links; no request is taken during it
// a result waits in the output register while rsp_tready is low; the next request
// is taken only once it has left
module indexed_linked_list_manager_unit
   import illm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // opcode, position, second_position, value, zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata    // status, slot, at_end, front, back, count, zero pad
);
   // sequencer states
   localparam logic [3:0] S_SWEEP = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RD1   = 4'd2;  // first read issued
   localparam logic [3:0] S_EVAL  = 4'd3;  // first read data back
   localparam logic [3:0] S_RD2   = 4'd4;  // second read
   localparam logic [3:0] S_W1    = 4'd5;
   localparam logic [3:0] S_W2    = 4'd6;
   localparam logic [3:0] S_W3    = 4'd7;
   localparam logic [3:0] S_SWP1  = 4'd8;
   localparam logic [3:0] S_SWP2  = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [7:0]  sweep_ff, sweep_in;
   logic [3:0]  op_ff, op_in;
   logic [7:0]  pos_ff, pos_in, pos2_ff, pos2_in;
   logic [63:0] val_ff, val_in, tmp_ff, tmp_in;
   logic [7:0]  front_ff, front_in, back_ff, back_in, free_ff, free_in, cnt_ff, cnt_in;
   logic [7:0]  s_ff, s_in, p_ff, p_in, n_ff, n_in;   // working slot and its neighbors
   logic [2:0]  st_ff, st_in;
   logic [7:0]  slot_ff, slot_in;
   logic        end_ff, end_in;
   logic        rv_ff, rv_in;
   logic [39:0] rd_ff, rd_in;

   // memory ports
   logic        nx_we, dp_we;
   logic [7:0]  nx_wa, dp_wa, nx_ra, dp_ra;
   node_type    nx_wd, nx_rd;
   word_type    dp_wd, dp_rd;

   illm_ram #(.WIDTH($bits(node_type)), .DEPTH(256)) u_next (
      .clock(clock), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_addr(nx_ra), .rd_data(nx_rd));
   illm_ram #(.WIDTH($bits(word_type)), .DEPTH(256)) u_word (
      .clock(clock), .wr_en(dp_we), .wr_addr(dp_wa), .wr_data(dp_wd),
      .rd_addr(dp_ra), .rd_data(dp_rd));

   logic is_ins, is_push;
   assign is_push = (op_ff == OP_PUSH_FRONT) || (op_ff == OP_PUSH_BACK);
   assign is_ins  = (op_ff == OP_INS_BEFORE) || (op_ff == OP_INS_AFTER);

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   always_comb begin
      state_in = state_ff; sweep_in = sweep_ff;
      op_in = op_ff; pos_in = pos_ff; pos2_in = pos2_ff; val_in = val_ff; tmp_in = tmp_ff;
      front_in = front_ff; back_in = back_ff; free_in = free_ff; cnt_in = cnt_ff;
      s_in = s_ff; p_in = p_ff; n_in = n_ff;
      st_in = st_ff; slot_in = slot_ff; end_in = end_ff;
      rv_in = rv_ff && !rsp_tready; rd_in = rd_ff;
      nx_we = 1'b0; dp_we = 1'b0;
      nx_wa = s_ff; dp_wa = s_ff;
      nx_wd = '{link: 8'd0, used: 1'b0};
      dp_wd = '{value: val_ff, prev: p_ff};
      nx_ra = pos_ff; dp_ra = pos_ff;
      case (state_ff)
         S_SWEEP: begin
            // rebuild next links: sentinel 0, free chain i+1, all unused
            nx_we = 1'b1; nx_wa = sweep_ff;
            nx_wd = '{link: (sweep_ff == 8'd0) ? 8'd0 : sweep_ff + 8'd1, used: 1'b0};
            sweep_in = sweep_ff + 8'd1;
            if (sweep_ff == 8'hff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in = req_tdata[3:0]; pos_in = req_tdata[11:4];
               pos2_in = req_tdata[19:12]; val_in = req_tdata[83:20];
               st_in = ST_OK; slot_in = 8'd0; end_in = 1'b0;
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            // decide which entry to fetch first
            state_in = S_EVAL;
            case (op_ff)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  nx_ra = free_ff;
                  s_in = free_ff;
                  p_in = (op_ff == OP_PUSH_FRONT) ? 8'd0 : back_ff;
                  n_in = (op_ff == OP_PUSH_FRONT) ? front_ff : 8'd0;
               end
               OP_POP_FRONT: begin nx_ra = front_ff; dp_ra = front_ff; s_in = front_ff; end
               OP_POP_BACK:  begin nx_ra = back_ff;  dp_ra = back_ff;  s_in = back_ff;  end
               OP_SWAP:      begin dp_ra = pos_ff; end
               default:      begin nx_ra = pos_ff; dp_ra = pos_ff; s_in = pos_ff; end
            endcase
         end
         S_EVAL: begin
            state_in = S_DONE;
            case (op_ff)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  if (is_nan(val_ff)) st_in = ST_NAN;
                  else if (cnt_ff >= EFF_CAP) st_in = ST_FULL;
                  else begin free_in = nx_rd.link; state_in = S_W1; end
               end
               OP_INS_BEFORE, OP_INS_AFTER: begin
                  if (is_nan(val_ff)) st_in = ST_NAN;
                  else if (!in_range(pos_ff)) st_in = ST_BADPOS;
                  else if (!nx_rd.used && cnt_ff != 8'd0) st_in = ST_NOTIN;
                  else if (cnt_ff >= EFF_CAP) st_in = ST_FULL;
                  else begin
                     if (cnt_ff == 8'd0) begin p_in = 8'd0; n_in = 8'd0; end
                     else if (op_ff == OP_INS_BEFORE) begin
                        p_in = dp_rd.prev; n_in = pos_ff;
                     end
                     else begin p_in = pos_ff; n_in = nx_rd.link; end
                     nx_ra = free_ff; s_in = free_ff;
                     state_in = S_RD2;
                  end
               end
               OP_ERASE, OP_POP_FRONT, OP_POP_BACK: begin
                  if (op_ff == OP_ERASE && !in_range(pos_ff)) st_in = ST_BADPOS;
                  else if (op_ff == OP_ERASE && !nx_rd.used) st_in = ST_NOTIN;
                  else if (op_ff != OP_ERASE && cnt_ff == 8'd0) st_in = ST_EMPTY;
                  else begin p_in = dp_rd.prev; n_in = nx_rd.link; state_in = S_W1; end
               end
               OP_CLEAR: begin
                  // answer first, then sweep
                  front_in = 8'd0; back_in = 8'd0; free_in = 8'd1; cnt_in = 8'd0;
                  sweep_in = 8'd0;
               end
               OP_NEXT, OP_PREV: begin
                  if (!in_range(pos_ff)) st_in = ST_BADPOS;
                  else if (!nx_rd.used) st_in = ST_NOTIN;
                  else if (op_ff == OP_NEXT) begin
                     if (pos_ff == back_ff) end_in = 1'b1; else slot_in = nx_rd.link;
                  end else begin
                     if (pos_ff == front_ff) end_in = 1'b1; else slot_in = dp_rd.prev;
                  end
               end
               OP_SWAP: begin
                  if (!in_range(pos_ff) || !in_range(pos2_ff)) st_in = ST_BADPOS;
                  else begin
                     // keep value and prev link of pos, fetch pos2
                     tmp_in = dp_rd.value; p_in = dp_rd.prev;
                     dp_ra = pos2_ff; state_in = S_SWP1;
                  end
               end
               default: ;
            endcase
         end
         S_RD2: begin
            free_in = nx_rd.link;
            state_in = S_W1;
         end
         S_W1: begin
            state_in = S_W2;
            // fetch the word of n so its value survives the prev update
            dp_ra = n_ff;
            if (is_push || is_ins) begin
               // new node
               nx_we = 1'b1; nx_wa = s_ff; nx_wd = '{link: n_ff, used: 1'b1};
               dp_we = 1'b1; dp_wa = s_ff; dp_wd = '{value: val_ff, prev: p_ff};
            end else begin
               // retire node to the free chain
               nx_we = 1'b1; nx_wa = s_ff; nx_wd = '{link: free_ff, used: 1'b0};
               free_in = s_ff;
            end
         end
         S_W2: begin
            // next_link[p] needs its used bit: read p now, write next cycle
            nx_ra = p_ff;
            dp_we = 1'b1; dp_wa = n_ff;
            dp_wd = '{value: dp_rd.value, prev: (is_push || is_ins) ? s_ff : p_ff};
            state_in = S_W3;
         end
         S_W3: begin
            nx_we = 1'b1; nx_wa = p_ff;
            nx_wd = '{link: (is_push || is_ins) ? s_ff : n_ff, used: nx_rd.used};
            if (p_ff == 8'd0) front_in = (is_push || is_ins) ? s_ff : n_ff;
            if (n_ff == 8'd0) back_in = (is_push || is_ins) ? s_ff : p_ff;
            if (is_push || is_ins) begin cnt_in = cnt_ff + 8'd1; slot_in = s_ff; end
            else cnt_in = cnt_ff - 8'd1;
            state_in = S_DONE;
         end
         S_SWP1: begin
            // pos2 gets the value of pos; its old value is on dp_rd now
            dp_we = 1'b1; dp_wa = pos2_ff; dp_wd = '{value: tmp_ff, prev: dp_rd.prev};
            tmp_in = dp_rd.value;
            state_in = S_SWP2;
         end
         S_SWP2: begin
            dp_we = 1'b1; dp_wa = pos_ff; dp_wd = '{value: tmp_ff, prev: p_ff};
            state_in = S_DONE;
         end
         S_DONE: begin
            rv_in = 1'b1;
            rd_in = {4'd0, cnt_ff, back_ff, front_ff, end_ff, slot_ff, st_ff};
            state_in = (op_ff == OP_CLEAR) ? S_SWEEP : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP; sweep_ff <= 8'd0; rv_ff <= 1'b0;
         front_ff <= 8'd0; back_ff <= 8'd0; free_ff <= 8'd1; cnt_ff <= 8'd0;
      end else begin
         state_ff <= state_in; sweep_ff <= sweep_in; rv_ff <= rv_in;
         front_ff <= front_in; back_ff <= back_in; free_ff <= free_in; cnt_ff <= cnt_in;
      end
      op_ff <= op_in; pos_ff <= pos_in; pos2_ff <= pos2_in; val_ff <= val_in;
      tmp_ff <= tmp_in; s_ff <= s_in; p_ff <= p_in; n_ff <= n_in;
      st_ff <= st_in; slot_ff <= slot_in; end_ff <= end_in; rd_ff <= rd_in;
   end
endmodule

// ----- hw/rtl/illm_checker.sv -----
module illm_checker
   import illm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken with result pending");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_FULL)
      else $error("bad status code");
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> rsp_tdata[10:3] == 8'd0)
      else $error("end flag with slot");
   a_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[35:28] == 8'd0) |-> rsp_tdata[19:12] == 8'd0)
      else $error("empty list with a front");
endmodule

bind indexed_linked_list_manager_unit illm_checker u_illm_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
